@@ hdl/gble_pkg.sv @@
package gble_pkg;

	// buffer geometry
	localparam int BUFFER_SIZE = 4096;
	localparam int MAX_LINES   = 1024;

	localparam int POS_W   = 13;
	localparam int LINE_W  = 11;
	localparam int TADDR_W = 12;
	localparam int LADDR_W = 10;
	localparam int ENTRY_W = 12;

	localparam logic [7:0] NEWLINE = 8'd10;

	// request kinds
	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_DELETE = 3'd1,
		KIND_MOVE_CHARS = 3'd2,
		KIND_MOVE_ABS = 3'd3,
		KIND_MOVE_LINES = 3'd4
	} kind_t;

endpackage

@@ hdl/gble_ram.sv @@
module gble_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/gap_buffer_line_index_editor.sv @@
// channel   direction  handshake             payload
// request   in         req_valid/req_stall   kind, character, amount, position
// result    out        res_valid/res_stall   status, cursor, column, line_index,
//                                            line_total, text_length
//
// one request at a time; a newline insert or delete also shifts the line
// index entry of every newline after the cursor; cursor moves carry each
// character crossed across the gap, and line moves first scan the target
// line character by character
// reset clears state, res_valid, gap and line counters only; text and newline
// memories need no clearing; a held result does not block the next request
module gap_buffer_line_index_editor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [2:0]                       kind,
	input  logic [7:0]                       character,
	input  logic signed [13:0]               amount,
	input  logic [gble_pkg::POS_W-1:0]       position,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic                             status,
	output logic [gble_pkg::POS_W-1:0]       cursor,
	output logic [gble_pkg::POS_W-1:0]       column,
	output logic [gble_pkg::LINE_W-1:0]      line_index,
	output logic [gble_pkg::LINE_W-1:0]      line_total,
	output logic [gble_pkg::POS_W-1:0]       text_length
);

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_DISP    = 16'h0002,
		S_INS_WR  = 16'h0004,
		S_INS_FIN = 16'h0008,
		S_DEL_CHK = 16'h0010,
		S_DEL_WR  = 16'h0020,
		S_DEL_FIN = 16'h0040,
		S_MOVE    = 16'h0080,
		S_MV_FWD  = 16'h0100,
		S_MV_BWD  = 16'h0200,
		S_ML_A    = 16'h0400,
		S_ML_B    = 16'h0800,
		S_ML_SCAN = 16'h1000,
		S_ML_CHK  = 16'h2000,
		S_COL     = 16'h4000,
		S_RPT     = 16'h8000
	} state_t;

	localparam logic [gble_pkg::POS_W-1:0] BUF_END = gble_pkg::POS_W'(gble_pkg::BUFFER_SIZE);
	localparam logic [gble_pkg::LINE_W-1:0] LINE_MAX = gble_pkg::LINE_W'(gble_pkg::MAX_LINES);

	state_t state_q, state_d;
	logic [gble_pkg::POS_W-1:0] gf_q, gf_d, gb_q, gb_d;
	logic [gble_pkg::LINE_W-1:0] lbg_q, lbg_d, lc_q, lc_d;
	gble_pkg::kind_t kind_q;
	logic [7:0] char_q;
	logic signed [13:0] amt_q;
	logic [gble_pkg::POS_W-1:0] pos_q;
	logic stat_q, stat_d;
	logic [gble_pkg::LADDR_W-1:0] i_q, i_d;
	logic [gble_pkg::POS_W-1:0] dest_q, dest_d, col_q, col_d, p_q, p_d;
	logic [gble_pkg::LINE_W-1:0] tgt_q, tgt_d;

	logic res_valid_q, out_load;
	logic status_q;
	logic [gble_pkg::POS_W-1:0] cursor_q, column_q, len_out_q;
	logic [gble_pkg::LINE_W-1:0] lidx_q, ltot_q;

	// memory ports
	logic t_we, t_re, l_we, l_re;
	logic [gble_pkg::TADDR_W-1:0] t_wa, t_ra;
	logic [7:0] t_wd, t_rd;
	logic [gble_pkg::LADDR_W-1:0] l_wa, l_ra;
	logic [gble_pkg::ENTRY_W-1:0] l_wd, l_rd;

	// derived quantities
	logic [gble_pkg::POS_W-1:0] len, gapw, col_now, logical, phys;
	logic [gble_pkg::LINE_W-1:0] lbg_m1, tgt_m1;
	logic signed [14:0] csum;
	logic signed [14:0] lsum;

	assign len = gf_q + (BUF_END - gb_q);
	assign gapw = gb_q - gf_q;
	assign lbg_m1 = lbg_q - 1'b1;
	assign tgt_m1 = tgt_q - 1'b1;
	assign col_now = (lbg_q != '0) ? gf_q - ({1'b0, l_rd} + 1'b1) : gf_q;
	assign logical = (tgt_m1 < lbg_q) ? {1'b0, l_rd} : {1'b0, l_rd} - gapw;
	assign phys = (p_q < gf_q) ? p_q : p_q + gapw;
	assign csum = $signed({2'b00, gf_q}) + $signed({amt_q[13], amt_q});
	assign lsum = $signed({4'b0000, lbg_q}) + $signed({amt_q[13], amt_q});

	assign out_load = (state_q == S_RPT) && (!res_valid_q || !res_stall);
	assign req_stall = (state_q != S_IDLE);

	// sequencer next state and memory access
	always_comb begin
		state_d = state_q;
		gf_d = gf_q;
		gb_d = gb_q;
		lbg_d = lbg_q;
		lc_d = lc_q;
		stat_d = stat_q;
		i_d = i_q;
		dest_d = dest_q;
		col_d = col_q;
		p_d = p_q;
		tgt_d = tgt_q;
		t_we = 1'b0;
		t_wa = gf_q[gble_pkg::TADDR_W-1:0];
		t_wd = char_q;
		t_re = 1'b0;
		t_ra = gf_q[gble_pkg::TADDR_W-1:0];
		l_we = 1'b0;
		l_wa = lbg_q[gble_pkg::LADDR_W-1:0];
		l_wd = gf_q[gble_pkg::ENTRY_W-1:0];
		l_re = 1'b0;
		l_ra = lbg_m1[gble_pkg::LADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISP;
					stat_d = 1'b0;
				end
			end
			S_DISP: begin
				state_d = S_COL;
				case (kind_q)
					gble_pkg::KIND_INSERT: begin
						if (gf_q >= gb_q) begin
							stat_d = 1'b1;
						end else if (char_q == gble_pkg::NEWLINE) begin
							if (lc_q >= LINE_MAX) begin
								stat_d = 1'b1;
							end else if (lc_q == lbg_q) begin
								state_d = S_INS_FIN;
							end else begin
								i_d = gble_pkg::LADDR_W'(lc_q - 1'b1);
								l_re = 1'b1;
								l_ra = gble_pkg::LADDR_W'(lc_q - 1'b1);
								state_d = S_INS_WR;
							end
						end else begin
							t_we = 1'b1;
							gf_d = gf_q + 1'b1;
						end
					end
					gble_pkg::KIND_DELETE: begin
						if (gf_q == '0) begin
							stat_d = 1'b1;
						end else begin
							t_re = 1'b1;
							t_ra = gble_pkg::TADDR_W'(gf_q - 1'b1);
							gf_d = gf_q - 1'b1;
							state_d = S_DEL_CHK;
						end
					end
					gble_pkg::KIND_MOVE_CHARS: begin
						if (csum < 0) begin
							dest_d = '0;
						end else if (csum > $signed({2'b00, len})) begin
							dest_d = len;
						end else begin
							dest_d = csum[gble_pkg::POS_W-1:0];
						end
						state_d = S_MOVE;
					end
					gble_pkg::KIND_MOVE_ABS: begin
						dest_d = (pos_q > len) ? len : pos_q;
						state_d = S_MOVE;
					end
					gble_pkg::KIND_MOVE_LINES: begin
						if (lsum < 0) begin
							tgt_d = '0;
						end else if (lsum > $signed({4'b0000, lc_q})) begin
							tgt_d = lc_q;
						end else begin
							tgt_d = lsum[gble_pkg::LINE_W-1:0];
						end
						if (!(lsum <= 0 && lbg_q == '0) && !(lsum >= $signed({4'b0000, lc_q})
								&& lbg_q == lc_q) && lsum != $signed({4'b0000, lbg_q})) begin
							l_re = (lbg_q != '0);
							state_d = S_ML_A;
						end
					end
					default: begin
						state_d = S_COL;
					end
				endcase
			end
			// shift entries after the cursor up by one, highest first
			S_INS_WR: begin
				l_we = 1'b1;
				l_wa = i_q + 1'b1;
				l_wd = l_rd;
				if ({1'b0, i_q} == lbg_q) begin
					state_d = S_INS_FIN;
				end else begin
					l_re = 1'b1;
					l_ra = i_q - 1'b1;
					i_d = i_q - 1'b1;
				end
			end
			S_INS_FIN: begin
				l_we = 1'b1;
				t_we = 1'b1;
				lbg_d = lbg_q + 1'b1;
				lc_d = lc_q + 1'b1;
				gf_d = gf_q + 1'b1;
				state_d = S_COL;
			end
			S_DEL_CHK: begin
				state_d = S_COL;
				if (t_rd == gble_pkg::NEWLINE && lbg_q != '0) begin
					if (lbg_q == lc_q) begin
						state_d = S_DEL_FIN;
					end else begin
						l_re = 1'b1;
						l_ra = lbg_q[gble_pkg::LADDR_W-1:0];
						i_d = lbg_q[gble_pkg::LADDR_W-1:0];
						state_d = S_DEL_WR;
					end
				end
			end
			// shift entries after the cursor down by one, lowest first
			S_DEL_WR: begin
				l_we = 1'b1;
				l_wa = i_q - 1'b1;
				l_wd = l_rd;
				if (({1'b0, i_q} + 1'b1) == lc_q) begin
					state_d = S_DEL_FIN;
				end else begin
					l_re = 1'b1;
					l_ra = i_q + 1'b1;
					i_d = i_q + 1'b1;
				end
			end
			S_DEL_FIN: begin
				lbg_d = lbg_q - 1'b1;
				lc_d = lc_q - 1'b1;
				state_d = S_COL;
			end
			// carry characters across the gap one at a time, reading then writing each
			S_MOVE: begin
				if (dest_q > gf_q) begin
					t_re = 1'b1;
					t_ra = gb_q[gble_pkg::TADDR_W-1:0];
					state_d = S_MV_FWD;
				end else if (dest_q < gf_q) begin
					t_re = 1'b1;
					t_ra = gble_pkg::TADDR_W'(gf_q - 1'b1);
					state_d = S_MV_BWD;
				end else begin
					state_d = S_COL;
				end
			end
			S_MV_FWD: begin
				t_we = 1'b1;
				t_wd = t_rd;
				if (t_rd == gble_pkg::NEWLINE && lbg_q < LINE_MAX) begin
					l_we = 1'b1;
					lbg_d = lbg_q + 1'b1;
				end
				gf_d = gf_q + 1'b1;
				gb_d = gb_q + 1'b1;
				state_d = S_MOVE;
			end
			S_MV_BWD: begin
				t_we = 1'b1;
				t_wa = gble_pkg::TADDR_W'(gb_q - 1'b1);
				t_wd = t_rd;
				if (t_rd == gble_pkg::NEWLINE && lbg_q != '0) begin
					l_we = 1'b1;
					l_wa = lbg_m1[gble_pkg::LADDR_W-1:0];
					l_wd = gble_pkg::ENTRY_W'(gb_q - 1'b1);
					lbg_d = lbg_q - 1'b1;
				end
				gf_d = gf_q - 1'b1;
				gb_d = gb_q - 1'b1;
				state_d = S_MOVE;
			end
			// line move: column, then start of the target line
			S_ML_A: begin
				col_d = col_now;
				l_re = (tgt_q != '0);
				l_ra = tgt_m1[gble_pkg::LADDR_W-1:0];
				state_d = S_ML_B;
			end
			S_ML_B: begin
				p_d = (tgt_q != '0) ? logical + 1'b1 : '0;
				state_d = S_ML_SCAN;
			end
			S_ML_SCAN: begin
				if (p_q < len && col_q != '0) begin
					t_re = 1'b1;
					t_ra = phys[gble_pkg::TADDR_W-1:0];
					state_d = S_ML_CHK;
				end else begin
					dest_d = p_q;
					state_d = S_MOVE;
				end
			end
			S_ML_CHK: begin
				if (t_rd == gble_pkg::NEWLINE) begin
					dest_d = p_q;
					state_d = S_MOVE;
				end else begin
					p_d = p_q + 1'b1;
					col_d = col_q - 1'b1;
					state_d = S_ML_SCAN;
				end
			end
			S_COL: begin
				l_re = (lbg_q != '0);
				state_d = S_RPT;
			end
			S_RPT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gf_q <= '0;
			gb_q <= BUF_END;
			lbg_q <= '0;
			lc_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gf_q <= gf_d;
			gb_q <= gb_d;
			lbg_q <= lbg_d;
			lc_q <= lc_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// request fields and working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			kind_q <= gble_pkg::kind_t'(kind);
			char_q <= character;
			amt_q <= amount;
			pos_q <= position;
		end
		stat_q <= stat_d;
		i_q <= i_d;
		dest_q <= dest_d;
		col_q <= col_d;
		p_q <= p_d;
		tgt_q <= tgt_d;
		if (out_load) begin
			status_q <= stat_q;
			cursor_q <= gf_q;
			column_q <= col_now;
			lidx_q <= lbg_q;
			ltot_q <= lc_q;
			len_out_q <= len;
		end
	end

	gble_ram #(
		.WIDTH(8),
		.DEPTH(gble_pkg::BUFFER_SIZE)
	) u_text (
		.clk(clk),
		.we(t_we),
		.waddr(t_wa),
		.wdata(t_wd),
		.re(t_re),
		.raddr(t_ra),
		.rdata(t_rd)
	);

	gble_ram #(
		.WIDTH(gble_pkg::ENTRY_W),
		.DEPTH(gble_pkg::MAX_LINES)
	) u_lines (
		.clk(clk),
		.we(l_we),
		.waddr(l_wa),
		.wdata(l_wd),
		.re(l_re),
		.raddr(l_ra),
		.rdata(l_rd)
	);

	assign res_valid = res_valid_q;
	assign status = status_q;
	assign cursor = cursor_q;
	assign column = column_q;
	assign line_index = lidx_q;
	assign line_total = ltot_q;
	assign text_length = len_out_q;

endmodule
